// ----- design/i2p_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character codes and lookup functions of the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int DefStackDepth = 16;

  // Stack entry codes
  typedef logic [2:0] code_t;
  localparam code_t CODE_NONE  = 3'd0;
  localparam code_t CODE_LPAR  = 3'd1;
  localparam code_t CODE_PLUS  = 3'd2;
  localparam code_t CODE_MINUS = 3'd3;
  localparam code_t CODE_MUL   = 3'd4;
  localparam code_t CODE_DIV   = 3'd5;
  localparam code_t CODE_POW   = 3'd6;

  // ASCII characters of interest
  localparam logic [7:0] CHAR_LPAR  = 8'h28;
  localparam logic [7:0] CHAR_RPAR  = 8'h29;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_CARET = 8'h5E;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Sticky status codes
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_OVERFLOW  = 2'd1;
  localparam err_t ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    code_t code;
  } stk_ctrl_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    code_t top;
  } stk_stat_t;

  function automatic code_t op_code_of(input logic [7:0] c);
    code_t r;
    case (c)
      CHAR_PLUS:  r = CODE_PLUS;
      CHAR_MINUS: r = CODE_MINUS;
      CHAR_STAR:  r = CODE_MUL;
      CHAR_SLASH: r = CODE_DIV;
      CHAR_CARET: r = CODE_POW;
      default:    r = CODE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input code_t c);
    logic [7:0] r;
    case (c)
      CODE_LPAR:  r = CHAR_LPAR;
      CODE_PLUS:  r = CHAR_PLUS;
      CODE_MINUS: r = CHAR_MINUS;
      CODE_MUL:   r = CHAR_STAR;
      CODE_DIV:   r = CHAR_SLASH;
      CODE_POW:   r = CHAR_CARET;
      default:    r = CHAR_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] code_prec(input code_t c);
    logic [1:0] r;
    case (c) inside
      CODE_PLUS, CODE_MINUS: r = 2'd1;
      CODE_MUL, CODE_DIV:    r = 2'd2;
      CODE_POW:              r = 2'd3;
      default:               r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

// ----- design/infix_to_postfix_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one infix character word per handshake (char_code_i, with
//   last_char_i on the final character). A word is taken when in_valid_i is
//   high and in_stall_o low. Output channel: one postfix word per handshake,
//   taken when out_valid_o is high and out_stall_i low; end_of_output_o marks
//   the final word of an expression, has_char_o low marks a bare end word.
//   status_o carries the sticky error of the expression so far.
// Operation:
//   One word is in work at a time. A letter, digit, '(' or ignored character
//   is handled without any stack pop; every operator popped off the stack
//   for an operator or ')' is a single-entry shift of the cell chain.
//   A last word then flushes every stacked entry and emits the end word.
//   Output words are registered before they appear on the output.
// Reset:
//   rst_ni clears the stack fill count, sticky error and both valids.
// Stall:
//   A stalled output holds its word; the block keeps working until it needs
//   the output register again, then waits with in_stall_o high.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = i2p_pkg::DefStackDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       has_char_o,
  output logic       end_of_output_o,
  output logic [1:0] status_o
);
  import i2p_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WORK   = 4'b0010,
    S_FLUSH  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] char_q;
  logic       last_q;
  err_t       sticky_q;

  // pending word of the last character, held back until its end flag is known
  logic       pend_v_q;
  logic [7:0] pend_char_q;
  err_t       pend_status_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_has_q;
  logic       out_end_q;
  err_t       out_status_q;

  stk_ctrl_t  stk_ctrl;
  stk_stat_t  stk_stat;

  logic       out_free;
  logic       can_emit;
  logic       produce;
  logic [7:0] prod_char;
  logic       err_set;
  err_t       err_code;
  logic       fin;
  code_t      cur_code;
  logic       pop_op;
  state_e     after_st;

  logic       load_out;
  logic [7:0] ld_char;
  logic       ld_has;
  logic       ld_end;
  err_t       ld_status;

  i2p_op_stack #(
    .StackDepth(STACK_DEPTH)
  ) u_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(stk_ctrl),
    .stat_o(stk_stat)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  // a last word parks in the pending slot, others go straight out
  assign can_emit = last_q ? (!pend_v_q || out_free) : out_free;
  assign cur_code = op_code_of(char_q);
  assign after_st = last_q ? S_FLUSH : S_IDLE;
  // pop the top while it binds at least as tightly as the incoming operator
  assign pop_op   = !stk_stat.empty && (stk_stat.top != CODE_LPAR) &&
                    (code_prec(stk_stat.top) >= code_prec(cur_code));

  always_comb begin
    state_d       = state_q;
    stk_ctrl      = '0;
    stk_ctrl.code = cur_code;
    produce       = 1'b0;
    prod_char     = code_char(stk_stat.top);
    err_set       = 1'b0;
    err_code      = ERR_NONE;
    fin           = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_WORK;
        end
      end
      S_WORK: begin
        if (is_alnum(char_q)) begin
          if (can_emit) begin
            produce   = 1'b1;
            prod_char = char_q;
            state_d   = after_st;
          end
        end else if (char_q == CHAR_LPAR) begin
          stk_ctrl.code = CODE_LPAR;
          if (stk_stat.full) begin
            err_set  = 1'b1;
            err_code = ERR_OVERFLOW;
          end else begin
            stk_ctrl.push = 1'b1;
          end
          state_d = after_st;
        end else if (cur_code != CODE_NONE) begin
          if (pop_op) begin
            if (can_emit) begin
              produce      = 1'b1;
              stk_ctrl.pop = 1'b1;
            end
          end else begin
            if (stk_stat.full) begin
              err_set  = 1'b1;
              err_code = ERR_OVERFLOW;
            end else begin
              stk_ctrl.push = 1'b1;
            end
            state_d = after_st;
          end
        end else if (char_q == CHAR_RPAR) begin
          if (stk_stat.empty) begin
            err_set  = 1'b1;
            err_code = ERR_UNMATCHED;
            state_d  = after_st;
          end else if (stk_stat.top == CODE_LPAR) begin
            stk_ctrl.pop = 1'b1;
            state_d      = after_st;
          end else if (can_emit) begin
            produce      = 1'b1;
            stk_ctrl.pop = 1'b1;
          end
        end else begin
          state_d = after_st;
        end
      end
      S_FLUSH: begin
        if (stk_stat.empty) begin
          state_d = S_FINISH;
        end else if (stk_stat.top == CODE_LPAR) begin
          // drop an unmatched '('
          stk_ctrl.pop = 1'b1;
        end else if (can_emit) begin
          produce      = 1'b1;
          stk_ctrl.pop = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          fin            = 1'b1;
          stk_ctrl.clear = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register load: pending word, direct word, or end marker
  always_comb begin
    load_out  = 1'b0;
    ld_char   = prod_char;
    ld_has    = 1'b1;
    ld_end    = 1'b0;
    ld_status = sticky_q;
    if (fin) begin
      load_out = 1'b1;
      ld_end   = 1'b1;
      if (pend_v_q) begin
        ld_char   = pend_char_q;
        ld_status = pend_status_q;
      end else begin
        ld_char = CHAR_NUL;
        ld_has  = 1'b0;
      end
    end else if (produce) begin
      if (last_q) begin
        load_out  = pend_v_q;
        ld_char   = pend_char_q;
        ld_status = pend_status_q;
      end else begin
        load_out = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sticky_q    <= ERR_NONE;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin) begin
        sticky_q <= ERR_NONE;
      end else if (err_set && (sticky_q == ERR_NONE)) begin
        sticky_q <= err_code;
      end
      if (fin) begin
        pend_v_q <= 1'b0;
      end else if (produce && last_q) begin
        pend_v_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
    if (produce && last_q) begin
      pend_char_q   <= prod_char;
      pend_status_q <= sticky_q;
    end
    if (load_out) begin
      out_char_q   <= ld_char;
      out_has_q    <= ld_has;
      out_end_q    <= ld_end;
      out_status_q <= ld_status;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign has_char_o      = out_has_q;
  assign end_of_output_o = out_end_q;
  assign status_o        = out_status_q;

`ifndef ASSERT_OFF
  a_pend_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q)
    else $error("pending word left over between expressions");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH || state_q == S_FINISH) |-> last_q)
    else $error("flush entered for a word not marked last");

  a_sticky_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_q != 2'd3)
    else $error("sticky error holds an undefined code");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> (sticky_q == ERR_NONE) && stk_stat.empty)
    else $error("state not cleared after end of expression");
`endif

endmodule

// ----- design/i2p_stack_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_stack_cell
// One entry of the shifting operator stack; takes its neighbor's code on
// push or pop.
// ----------------------------------------------------------------------------
module i2p_stack_cell (
  input  logic              clk_i,
  input  i2p_pkg::stk_ctrl_t ctrl_i,
  input  i2p_pkg::code_t    from_above_i,
  input  i2p_pkg::code_t    from_below_i,
  output i2p_pkg::code_t    code_o
);
  import i2p_pkg::*;

  code_t code_q;

  // shift down on push, up on pop
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      code_q <= from_above_i;
    end else if (ctrl_i.pop) begin
      code_q <= from_below_i;
    end
  end

  assign code_o = code_q;

endmodule

// ----- design/i2p_op_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_op_stack
// Operator stack built as a chain of shifting cells plus a fill counter.
// ----------------------------------------------------------------------------
module i2p_op_stack #(
  parameter int StackDepth = i2p_pkg::DefStackDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2p_pkg::stk_ctrl_t ctrl_i,
  output i2p_pkg::stk_stat_t stat_o
);
  import i2p_pkg::*;

  localparam int CntW = $clog2(StackDepth + 1);

  code_t           cell_code [StackDepth];
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    code_t above;
    code_t below;
    if (i == 0) begin : g_head
      assign above = ctrl_i.code;
    end else begin : g_mid
      assign above = cell_code[i-1];
    end
    if (i == StackDepth - 1) begin : g_tail
      assign below = CODE_NONE;
    end else begin : g_body
      assign below = cell_code[i+1];
    end
    i2p_stack_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .from_above_i(above),
      .from_below_i(below),
      .code_o      (cell_code[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(StackDepth));
  assign stat_o.top   = cell_code[0];

endmodule
